### rtl/dense_matrix_multiply_core_defines.svh
// Assertion macros shared by the matrix multiply RTL.
`ifndef DENSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Checks a property on every rising clock edge outside reset.
`define DMM_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dmm assertion failed");
// Checks that a condition never holds outside reset.
`define DMM_ASSERT_NEVER(name, clk, rstn, cond) \
  name: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("dmm forbidden condition seen");
`else
`define DMM_ASSERT(name, clk, rstn, prop)
`define DMM_ASSERT_NEVER(name, clk, rstn, cond)
`endif
`endif

### rtl/dmm_pkg.sv
// Shared constants, types and helpers of the dense matrix multiply core.
`default_nettype none
package dmm_pkg;

  localparam int DMM_MAX_DIM = 8;
  localparam int ELEM_W      = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int SUM_W       = 35;
  localparam int IDX_OUT_W   = 3;
  localparam int CFG_W       = 4;
  localparam int CFG_IDX_W   = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;

  // Input opcodes.
  localparam logic OP_LOAD_B   = 1'b0;
  localparam logic OP_STREAM_A = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ADD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } dmm_state_e;

  // A programmed dimension of zero acts as one; above the maximum it saturates.
  function automatic int dmm_eff_dim(logic [CFG_W-1:0] v, int max_dim);
    int r;
    if (v == '0) begin
      r = 1;
    end else if (int'(v) > max_dim) begin
      r = max_dim;
    end else begin
      r = int'(v);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/dmm_if.sv
// Valid/ready channel interfaces for matrix elements in and result entries out.
`default_nettype none
interface dmm_in_if;
  import dmm_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [ELEM_W-1:0] element_value;

  modport source (output valid, opcode, element_value, input ready);
  modport sink   (input valid, opcode, element_value, output ready);
endinterface

interface dmm_out_if;
  import dmm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] product_sum;
  logic [IDX_OUT_W-1:0]    row_index;
  logic [IDX_OUT_W-1:0]    col_index;
  logic                    last;

  modport source (output valid, product_sum, row_index, col_index, last, input ready);
  modport sink   (input valid, product_sum, row_index, col_index, last, output ready);
endinterface
`default_nettype wire

### rtl/dmm_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none
module dmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic                                      re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### rtl/dmm_mac.sv
// Shared multiply-accumulate unit: registered 16x16 product, then 35-bit add.
`default_nettype none
module dmm_mac (
  input  wire logic                             clk_i,
  input  wire logic                             mul_en_i,
  input  wire logic signed [dmm_pkg::ELEM_W-1:0] elem_i,
  input  wire logic signed [dmm_pkg::ELEM_W-1:0] weight_i,
  input  wire logic                             acc_vld_i,
  input  wire logic signed [dmm_pkg::SUM_W-1:0]  acc_i,
  output      logic signed [dmm_pkg::SUM_W-1:0]  sum_o
);
  import dmm_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  acc_base;

  assign prod_d = elem_i * weight_i;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
    end
  end

  // An accumulator that was cleared since its last write reads as zero.
  assign acc_base = acc_vld_i ? acc_i : '0;
  assign sum_o    = acc_base + SUM_W'(prod_q);

endmodule
`default_nettype wire

### rtl/dense_matrix_multiply_core.sv
// Top level of the streaming dense matrix multiply core C = A x B.
// Usage: program rows_m, inner_k and cols_n, load B row-major with opcode 0,
// then stream A row-major with opcode 1. A B element is stored in the cycle it
// is accepted and the core is ready again in the next cycle. Each A element
// runs cols_n multiply-accumulates through the single shared MAC, each in three
// steps (weight and accumulator read, multiply, add and write back); the element
// that closes a row then returns cols_n result transactions, each read from the
// accumulator RAM and then offered until the sink takes it. The core takes
// one element at a time. A write to the rows_m, inner_k or cols_n register clears
// the B load position, the A row and column position and all accumulators; stored B is kept.
`default_nettype none
`include "dense_matrix_multiply_core_defines.svh"
module dense_matrix_multiply_core #(
  parameter int MAX_DIM = dmm_pkg::DMM_MAX_DIM
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [dmm_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [dmm_pkg::CFG_W-1:0]       cfg_data_i,
  dmm_in_if.sink                               in_ch,
  dmm_out_if.source                            out_ch
);
  import dmm_pkg::*;

  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int W_DEPTH = MAX_DIM * MAX_DIM;
  localparam int WAW    = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
  localparam int KN_W   = 2 * DIM_W;

  dmm_state_e state_q, state_d;

  logic [CFG_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] m_eff, k_eff, n_eff;
  logic [KN_W-1:0]  kn;

  logic [WAW-1:0]   b_cnt_q;
  logic [WAW-1:0]   base_q;
  logic [IDX_W-1:0] a_col_q;
  logic [IDX_W-1:0] row_q;
  logic [IDX_W-1:0] j_q;
  logic [MAX_DIM-1:0] acc_vld_q;
  logic             acc_rd_vld_q;
  logic signed [ELEM_W-1:0] elem_q;

  logic in_fire, out_fire, load_fire, stream_fire, cfg_hit;
  logic j_last, col_last, row_last;

  logic             w_we, w_re, a_re, a_we, mul_en;
  logic [WAW-1:0]   w_raddr;
  logic [ELEM_W-1:0] w_rdata;
  logic [SUM_W-1:0] a_rdata;
  logic signed [SUM_W-1:0] mac_sum;

  assign m_eff = DIM_W'(dmm_eff_dim(rows_q, MAX_DIM));
  assign k_eff = DIM_W'(dmm_eff_dim(inner_q, MAX_DIM));
  assign n_eff = DIM_W'(dmm_eff_dim(cols_q, MAX_DIM));
  assign kn    = KN_W'(k_eff) * KN_W'(n_eff);

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;
  assign load_fire   = in_fire && (in_ch.opcode == OP_LOAD_B);
  assign stream_fire = in_fire && (in_ch.opcode == OP_STREAM_A);
  assign cfg_hit     = cfg_we_i && ((cfg_idx_i == CFG_ROWS_M) || (cfg_idx_i == CFG_INNER_K)
                                    || (cfg_idx_i == CFG_COLS_N));

  assign j_last   = (DIM_W'(j_q) + DIM_W'(1)) == n_eff;
  assign col_last = (DIM_W'(a_col_q) + DIM_W'(1)) == k_eff;
  assign row_last = (DIM_W'(row_q) + DIM_W'(1)) == m_eff;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (stream_fire) begin
          state_d = ST_MAC_RD;
        end
      end
      ST_MAC_RD:  state_d = ST_MAC_MUL;
      ST_MAC_MUL: state_d = ST_MAC_ADD;
      ST_MAC_ADD: begin
        if (!j_last) begin
          state_d = ST_MAC_RD;
        end else if (col_last) begin
          state_d = ST_EMIT_RD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: state_d = ST_EMIT_OUT;
      ST_EMIT_OUT: begin
        if (out_fire) begin
          state_d = j_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output and datapath control decode.
  always_comb begin
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    w_re         = 1'b0;
    a_re         = 1'b0;
    a_we         = 1'b0;
    mul_en       = 1'b0;
    case (state_q)
      ST_IDLE:     in_ch.ready  = 1'b1;
      ST_MAC_RD: begin
        w_re = 1'b1;
        a_re = 1'b1;
      end
      ST_MAC_MUL:  mul_en       = 1'b1;
      ST_MAC_ADD:  a_we         = 1'b1;
      ST_EMIT_RD:  a_re         = 1'b1;
      ST_EMIT_OUT: out_ch.valid = 1'b1;
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  assign w_we    = load_fire;
  assign w_raddr = base_q + WAW'(j_q);

  assign out_ch.product_sum = a_rdata;
  assign out_ch.row_index   = IDX_OUT_W'(row_q);
  assign out_ch.col_index   = IDX_OUT_W'(j_q);
  assign out_ch.last        = j_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q       <= CFG_W'(1);
      inner_q      <= CFG_W'(1);
      cols_q       <= CFG_W'(1);
      b_cnt_q      <= '0;
      base_q       <= '0;
      a_col_q      <= '0;
      row_q        <= '0;
      j_q          <= '0;
      acc_vld_q    <= '0;
      acc_rd_vld_q <= 1'b0;
    end else if (cfg_hit) begin
      case (cfg_idx_i)
        CFG_ROWS_M:  rows_q  <= cfg_data_i;
        CFG_INNER_K: inner_q <= cfg_data_i;
        CFG_COLS_N:  cols_q  <= cfg_data_i;
        default:     rows_q  <= rows_q;
      endcase
      b_cnt_q   <= '0;
      base_q    <= '0;
      a_col_q   <= '0;
      row_q     <= '0;
      j_q       <= '0;
      acc_vld_q <= '0;
    end else begin
      if (load_fire) begin
        b_cnt_q <= ((KN_W'(b_cnt_q) + KN_W'(1)) >= kn) ? '0 : b_cnt_q + WAW'(1);
      end
      case (state_q)
        ST_MAC_RD: acc_rd_vld_q <= acc_vld_q[j_q];
        ST_MAC_ADD: begin
          acc_vld_q[j_q] <= 1'b1;
          if (!j_last) begin
            j_q <= j_q + IDX_W'(1);
          end else begin
            j_q <= '0;
            if (!col_last) begin
              a_col_q <= a_col_q + IDX_W'(1);
              base_q  <= base_q + WAW'(n_eff);
            end
          end
        end
        ST_EMIT_OUT: begin
          if (out_fire) begin
            acc_vld_q[j_q] <= 1'b0;
            if (!j_last) begin
              j_q <= j_q + IDX_W'(1);
            end else begin
              j_q     <= '0;
              a_col_q <= '0;
              base_q  <= '0;
              row_q   <= row_last ? '0 : row_q + IDX_W'(1);
            end
          end
        end
        default: acc_rd_vld_q <= acc_rd_vld_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (stream_fire) begin
      elem_q <= in_ch.element_value;
    end
  end

  dmm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (W_DEPTH)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (b_cnt_q),
    .wdata_i (in_ch.element_value),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  dmm_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_DIM)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (j_q),
    .wdata_i (mac_sum),
    .re_i    (a_re),
    .raddr_i (j_q),
    .rdata_o (a_rdata)
  );

  dmm_mac u_mac (
    .clk_i     (clk_i),
    .mul_en_i  (mul_en),
    .elem_i    (elem_q),
    .weight_i  (w_rdata),
    .acc_vld_i (acc_rd_vld_q),
    .acc_i     (a_rdata),
    .sum_o     (mac_sum)
  );

  // The load position of B always stays inside the programmed matrix.
  `DMM_ASSERT(a_bcnt_in_range, clk_i, rst_ni, (KN_W'(b_cnt_q) < kn))
  // A result is never offered while an input transaction can be taken.
  `DMM_ASSERT_NEVER(a_out_excl_in, clk_i, rst_ni, out_ch.valid && in_ch.ready)
  // Result columns stay below the programmed column count.
  `DMM_ASSERT(a_col_in_range, clk_i, rst_ni, out_ch.valid |-> (DIM_W'(j_q) < n_eff))
  // The final result of a row returns the core to idle.
  `DMM_ASSERT(a_last_to_idle, clk_i, rst_ni, out_fire && out_ch.last |=> state_q == ST_IDLE)
  // A B load never starts the multiply sequence.
  `DMM_ASSERT(a_load_stays_idle, clk_i, rst_ni, load_fire && !cfg_hit |=> state_q == ST_IDLE)

endmodule
`default_nettype wire

### bench/matmul_check_pkg.sv
`timescale 1ns / 1ps
// Scoreboard class that predicts and checks the result entries of the multiply core.
package matmul_check_pkg;
  import dmm_pkg::*;

  typedef struct packed {
    logic [SUM_W-1:0]     sum;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 last;
  } c_entry_t;

  class matmul_scoreboard;
    logic [CFG_W-1:0]         rows_reg;
    logic [CFG_W-1:0]         inner_reg;
    logic [CFG_W-1:0]         cols_reg;
    logic signed [ELEM_W-1:0] b_store [DMM_MAX_DIM*DMM_MAX_DIM];
    logic signed [SUM_W-1:0]  row_sums [DMM_MAX_DIM];
    int unsigned              b_pos;
    int unsigned              a_col;
    int unsigned              a_row;
    c_entry_t                 c_entries_due [$];
    int unsigned              mismatches;

    function new();
      rows_reg   = 4'd1;
      inner_reg  = 4'd1;
      cols_reg   = 4'd1;
      mismatches = 0;
      foreach (b_store[i]) b_store[i] = '0;
      clear_progress();
    endfunction

    // Zero acts as one and anything above the maximum is clamped to it.
    function int unsigned eff_dim(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (v > DMM_MAX_DIM) return DMM_MAX_DIM;
      return v;
    endfunction

    function void clear_progress();
      foreach (row_sums[i]) row_sums[i] = '0;
      b_pos = 0;
      a_col = 0;
      a_row = 0;
    endfunction

    function void write_dim(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_ROWS_M: rows_reg = val;
        CFG_INNER_K: inner_reg = val;
        CFG_COLS_N: cols_reg = val;
        default: return;
      endcase
      clear_progress();
    endfunction

    function void accept_element(logic op, logic signed [ELEM_W-1:0] val);
      int unsigned m;
      int unsigned k;
      int unsigned n;
      logic signed [PROD_W-1:0] prod;
      c_entry_t entry;
      m = eff_dim(rows_reg);
      k = eff_dim(inner_reg);
      n = eff_dim(cols_reg);
      if (op == OP_LOAD_B) begin
        if (b_pos >= k * n) b_pos = 0;
        b_store[b_pos] = val;
        b_pos = (b_pos + 1 >= k * n) ? 0 : b_pos + 1;
        return;
      end
      if (a_col >= k) a_col = 0;
      if (a_row >= m) a_row = 0;
      for (int unsigned j = 0; j < n; j++) begin
        prod = val * b_store[a_col * n + j];
        row_sums[j] = row_sums[j] + prod;
      end
      a_col++;
      if (a_col < k) return;
      for (int unsigned j = 0; j < n; j++) begin
        entry.sum  = row_sums[j];
        entry.row  = IDX_OUT_W'(a_row);
        entry.col  = IDX_OUT_W'(j);
        entry.last = (j + 1 == n);
        c_entries_due.push_back(entry);
        row_sums[j] = '0;
      end
      a_col = 0;
      a_row = (a_row + 1 >= m) ? 0 : a_row + 1;
    endfunction

    function void check_entry(c_entry_t got);
      c_entry_t want;
      if (c_entries_due.size() == 0) begin
        $error("result entry row %0d col %0d arrived with nothing expected", got.row, got.col);
        mismatches++;
        return;
      end
      want = c_entries_due.pop_front();
      if (got.sum !== want.sum) begin
        $error("product_sum: expected %0d, actual %0d", $signed(want.sum), $signed(got.sum));
        mismatches++;
      end
      if (got.row !== want.row) begin
        $error("row_index: expected %0d, actual %0d", want.row, got.row);
        mismatches++;
      end
      if (got.col !== want.col) begin
        $error("col_index: expected %0d, actual %0d", want.col, got.col);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return c_entries_due.size();
    endfunction
  endclass

endpackage

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench of the dense matrix multiply core: stimulus, result sink and watchdog.
module tb_top;
  import dmm_pkg::*;
  import matmul_check_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS  = 65;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  bit               steady;
  bit               hold_arm;
  bit               hold_req;
  int unsigned      items_sent = 0;
  int unsigned      stall_count = 0;
  matmul_scoreboard sb;

  dmm_in_if  in_ch ();
  dmm_out_if out_ch ();

  dense_matrix_multiply_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #5 clk_i = ~clk_i;

  // Mostly short gaps, now and then a long one, none at all in a steady phase.
  function automatic int unsigned pick_gap();
    int unsigned p;
    if (steady) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'hFFFF;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_dim();
    if ($urandom_range(0, 9) < 7) return CFG_W'($urandom_range(1, 4));
    return CFG_W'($urandom_range(0, 15));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic op, input logic [ELEM_W-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.element_value <= val;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.accept_element(op, val);
    items_sent++;
    if (hold_arm) begin
      hold_req = 1'b1;
      hold_arm = 1'b0;
    end
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_dim(idx, val);
    @(negedge clk_i);
  endtask

  task automatic program_dims(input logic [CFG_W-1:0] rows_val, inner_val, cols_val);
    write_reg(CFG_ROWS_M, rows_val);
    write_reg(CFG_INNER_K, inner_val);
    write_reg(CFG_COLS_N, cols_val);
    cfg_we_i <= 1'b0;
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // A row that is still open leaves the core busy with no entry due, hence the settle time.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic directed_tests();
    // Reset dimensions are 1 x 1 x 1, so every A element closes a row.
    send_item(OP_LOAD_B, 16'h8000);
    send_item(OP_STREAM_A, 16'h8000);
    send_item(OP_STREAM_A, 16'h7FFF);
    send_item(OP_STREAM_A, 16'hFFFF);
    send_item(OP_LOAD_B, 16'h7FFF);
    send_item(OP_STREAM_A, 16'h7FFF);
    send_item(OP_STREAM_A, 16'h0000);
    send_item(OP_STREAM_A, 16'h8000);
    wait_drained();
    // Zero and oversized register values; a B reload in the middle of a row.
    program_dims(4'd0, 4'd15, 4'd0);
    repeat (8) send_item(OP_LOAD_B, 16'h8000);
    repeat (4) send_item(OP_STREAM_A, 16'h8000);
    send_item(OP_LOAD_B, 16'h7FFF);
    repeat (4) send_item(OP_STREAM_A, 16'h8000);
    // This row is left open; the next register write must discard it.
    repeat (2) send_item(OP_STREAM_A, 16'h7FFF);
    wait_drained();
  endtask

  task automatic run_phase(input logic [CFG_W-1:0] rows_val, inner_val, cols_val,
                           input int unsigned reps, input bit hold_on_stream);
    int unsigned k;
    int unsigned n;
    int unsigned a_total;
    int unsigned a_done;
    program_dims(rows_val, inner_val, cols_val);
    k = sb.eff_dim(inner_val);
    n = sb.eff_dim(cols_val);
    // A full B load first, so that no A element reads an unwritten weight.
    repeat (k * n) send_item(OP_LOAD_B, rand_elem());
    hold_arm = hold_on_stream;
    a_total  = sb.eff_dim(rows_val) * k * reps + $urandom_range(0, k - 1);
    a_done   = 0;
    while (a_done < a_total) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item(OP_LOAD_B, rand_elem());
      end else begin
        send_item(OP_STREAM_A, rand_elem());
        a_done++;
      end
    end
    wait_drained();
  endtask

  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    c_entry_t got;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        got.sum  = out_ch.product_sum;
        got.row  = out_ch.row_index;
        got.col  = out_ch.col_index;
        got.last = out_ch.last;
        sb.check_entry(got);
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we_i) begin
        stall_count <= 0;
      end else begin
        stall_count <= stall_count + 1;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("** dense_matrix_multiply_core: FAILED **");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned burst_start;
    sb                  = new();
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_ROWS_M;
    cfg_data_i          = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_LOAD_B;
    in_ch.element_value = '0;
    out_ch.ready        = 1'b0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    directed_tests();
    burst_start = items_sent;
    // Full column count, with the sink holding off while A streams in.
    run_phase(4'd1, 4'd4, 4'd8, 2, 1'b1);
    // Eight rows of one element each, so the row number wraps.
    run_phase(4'd9, 4'd0, 4'd1, 2, 1'b0);
    while (items_sent - burst_start < RANDOM_ITEMS) begin
      run_phase(rand_dim(), rand_dim(), rand_dim(), $urandom_range(1, 2), 1'b0);
    end
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("** dense_matrix_multiply_core: PASSED **");
    end else begin
      $display("** dense_matrix_multiply_core: FAILED **");
    end
    $finish;
  end

endmodule
